FILE: src/hbd_pkg.sv
package hbd_pkg;

  // Width of length and chunk-size arithmetic; sizes saturate at 2^(LEN_BITS-1)-1.
  localparam int LEN_BITS = 32;
  localparam logic [LEN_BITS-1:0] SAT_MAX = {1'b0, {(LEN_BITS-1){1'b1}}};

  // Result status codes
  localparam logic [1:0] STAT_BODY     = 2'd0;
  localparam logic [1:0] STAT_END      = 2'd1;
  localparam logic [1:0] STAT_BAD_SIZE = 2'd2;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam int NAME_LEN_CHARS = 14;
  localparam int NAME_ENC_CHARS = 17;
  localparam int VAL_CHK_CHARS  = 8;

  localparam logic [8*NAME_LEN_CHARS-1:0] NAME_LEN_TXT = "Content-Length";
  localparam logic [8*NAME_ENC_CHARS-1:0] NAME_ENC_TXT = "Transfer-Encoding";
  localparam logic [8*VAL_CHK_CHARS-1:0]  VAL_CHK_TXT  = " chunked";

  typedef enum logic [3:0] {
    PH_STATUS = 4'd0,
    PH_NAME   = 4'd1,
    PH_VALUE  = 4'd2,
    PH_CLOSE  = 4'd3,
    PH_FIXED  = 4'd4,
    PH_SIZE   = 4'd5,
    PH_DATA   = 4'd6,
    PH_SKIP   = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    MODE_CLOSE   = 2'd0,
    MODE_FIXED   = 2'd1,
    MODE_CHUNKED = 2'd2
  } mode_t;

  // Content-Length number parse: leading blanks, after sign, in digits, stopped
  typedef enum logic [1:0] {
    NUM_LEAD   = 2'd0,
    NUM_SIGN   = 2'd1,
    NUM_DIGITS = 2'd2,
    NUM_STOP   = 2'd3
  } num_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

FILE: src/http_response_body_deframer.sv
// Channel   Handshake             Payload
// input     in_valid / in_ready   action, data_byte
// output    out_valid / out_ready body_byte, status, last
//
// One request per cycle while the output is not stalled: a byte is held in
// the input register, decoded by hbd_core once the output register is free,
// and any result it gives lands in the output register. The rate is set by the
// single state update per byte in hbd_core.
// rst (synchronous) empties both registers and returns to the status line.
// While out_ready is low the result holds, and in_ready drops once the input
// register holds a request.
module http_response_body_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] body_byte,
  output logic [1:0] status,
  output logic       last
);
  import hbd_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    take;
  logic    out_free;
  logic    res_valid;
  result_t res;

  // Advance the held request only when the output register can hold its result
  assign take = item_valid && out_free;

  hbd_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .data_byte  (data_byte),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Header parse and body framing state
  hbd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  hbd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .body_byte (body_byte),
    .status    (status),
    .last      (last)
  );

endmodule

FILE: src/hbd_in_reg.sv
module hbd_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           action,
  input  logic [7:0]     data_byte,
  input  logic           take,
  output logic           item_valid,
  output hbd_pkg::item_t item
);
  import hbd_pkg::*;

  // Free when empty or when the held request moves on this cycle
  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{action: action, data_byte: data_byte};
    end
  end

endmodule

FILE: src/hbd_core.sv
module hbd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  hbd_pkg::item_t   item,
  output logic             res_valid,
  output hbd_pkg::result_t res
);
  import hbd_pkg::*;

  typedef struct packed {
    phase_t              phase;
    logic                pending_cr;
    logic                line_empty;
    logic [4:0]          name_position;
    logic                length_name_hit;
    logic                encoding_name_hit;
    logic [3:0]          value_position;
    logic                chunked_value_hit;
    num_t                number_stage;
    logic                number_negative;
    mode_t               body_mode;
    logic [LEN_BITS-1:0] content_length;
    logic [LEN_BITS-1:0] remaining;
    logic [1:0]          skip_count;
  } st_t;

  localparam st_t ST_RESET = '{
    phase:             PH_STATUS,
    pending_cr:        1'b0,
    line_empty:        1'b1,
    name_position:     5'd0,
    length_name_hit:   1'b1,
    encoding_name_hit: 1'b1,
    value_position:    4'd0,
    chunked_value_hit: 1'b1,
    number_stage:      NUM_LEAD,
    number_negative:   1'b0,
    body_mode:         MODE_CLOSE,
    content_length:    '0,
    remaining:         '0,
    skip_count:        2'd0
  };

  function automatic logic [7:0] len_name_char(input logic [4:0] pos);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < NAME_LEN_CHARS; i++) begin
      if (pos == 5'(i)) c = NAME_LEN_TXT[8*(NAME_LEN_CHARS-1-i) +: 8];
    end
    return c;
  endfunction

  function automatic logic [7:0] enc_name_char(input logic [4:0] pos);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < NAME_ENC_CHARS; i++) begin
      if (pos == 5'(i)) c = NAME_ENC_TXT[8*(NAME_ENC_CHARS-1-i) +: 8];
    end
    return c;
  endfunction

  function automatic logic [7:0] chk_val_char(input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < VAL_CHK_CHARS; i++) begin
      if (pos == 4'(i)) c = VAL_CHK_TXT[8*(VAL_CHK_CHARS-1-i) +: 8];
    end
    return c;
  endfunction

  // acc*10 + d, saturating
  function automatic logic [LEN_BITS-1:0] sat_dec(input logic [LEN_BITS-1:0] acc,
                                                  input logic [3:0] d);
    logic [LEN_BITS+3:0] prod;
    prod = {4'b0000, acc} * (LEN_BITS+4)'(10) + {{LEN_BITS{1'b0}}, d};
    return (prod > {4'b0000, SAT_MAX}) ? SAT_MAX : prod[LEN_BITS-1:0];
  endfunction

  // acc*16 + d, saturating
  function automatic logic [LEN_BITS-1:0] sat_hex(input logic [LEN_BITS-1:0] acc,
                                                  input logic [3:0] d);
    logic [LEN_BITS+3:0] prod;
    prod = {acc, 4'b0000} + {{LEN_BITS{1'b0}}, d};
    return (prod > {4'b0000, SAT_MAX}) ? SAT_MAX : prod[LEN_BITS-1:0];
  endfunction

  // bit 4 set when the byte is a hex digit, low nibble its value
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b1, b[3:0]};
    else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
      v = {1'b1, b[3:0] + 4'd9};
    return v;
  endfunction

  function automatic st_t line_start(input st_t s);
    st_t r;
    r = s;
    r.line_empty        = 1'b1;
    r.name_position     = 5'd0;
    r.length_name_hit   = 1'b1;
    r.encoding_name_hit = 1'b1;
    r.value_position    = 4'd0;
    r.chunked_value_hit = 1'b1;
    r.number_stage      = NUM_LEAD;
    r.number_negative   = 1'b0;
    r.remaining         = '0;
    return r;
  endfunction

  // One byte of header text (status line, name or value)
  function automatic st_t text_byte(input st_t s, input logic [7:0] b);
    st_t  r;
    logic digit;
    logic blank;
    r = s;
    digit = (b >= 8'h30) && (b <= 8'h39);
    blank = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    r.line_empty = 1'b0;
    if (s.phase == PH_NAME) begin
      if (b == CHAR_COLON) begin
        r.phase = PH_VALUE;
      end else begin
        if (s.name_position >= 5'(NAME_LEN_CHARS) || b != len_name_char(s.name_position))
          r.length_name_hit = 1'b0;
        if (s.name_position >= 5'(NAME_ENC_CHARS) || b != enc_name_char(s.name_position))
          r.encoding_name_hit = 1'b0;
        if (s.name_position != 5'd31) r.name_position = s.name_position + 5'd1;
      end
    end else if (s.phase == PH_VALUE) begin
      if (s.value_position >= 4'(VAL_CHK_CHARS) || b != chk_val_char(s.value_position))
        r.chunked_value_hit = 1'b0;
      if (s.value_position != 4'd15) r.value_position = s.value_position + 4'd1;
      case (s.number_stage)
        NUM_LEAD: begin
          if (!blank) begin
            if (b == 8'h2D || b == 8'h2B) begin
              r.number_negative = (b == 8'h2D);
              r.number_stage    = NUM_SIGN;
            end else if (digit) begin
              r.remaining    = {{(LEN_BITS-4){1'b0}}, b[3:0]};
              r.number_stage = NUM_DIGITS;
            end else begin
              r.number_stage = NUM_STOP;
            end
          end
        end
        NUM_SIGN, NUM_DIGITS: begin
          if (digit) begin
            r.remaining    = sat_dec(s.remaining, b[3:0]);
            r.number_stage = NUM_DIGITS;
          end else begin
            r.number_stage = NUM_STOP;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  st_t                 st;
  st_t                 st_next;
  logic [7:0]          b;
  logic [4:0]          hex;
  logic [LEN_BITS-1:0] rem_dec;
  logic [1:0]          skip_dec;
  logic                crlf;

  assign b        = item.data_byte;
  assign hex      = hex_val(b);
  assign rem_dec  = (st.remaining != '0) ? st.remaining - LEN_BITS'(1) : '0;
  assign skip_dec = (st.skip_count != 2'd0) ? st.skip_count - 2'd1 : 2'd0;
  assign crlf     = st.pending_cr && (b == CHAR_LF);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else begin
      st <= st_next;
    end
  end

  // Next state
  always_comb begin
    st_t l;
    l       = st;
    st_next = st;
    if (take) begin
      if (item.action) begin
        if (st.phase != PH_DONE) begin
          st_next.phase      = PH_DONE;
          st_next.pending_cr = 1'b0;
        end
      end else begin
        unique case (st.phase) inside
          PH_STATUS, PH_NAME, PH_VALUE: begin
            if (crlf) begin
              if (st.line_empty) begin
                st_next.pending_cr = 1'b0;
                st_next.remaining  = '0;
                unique case (st.body_mode)
                  MODE_FIXED: begin
                    if (st.content_length == '0) begin
                      st_next.phase = PH_DONE;
                    end else begin
                      st_next.remaining = st.content_length;
                      st_next.phase     = PH_FIXED;
                    end
                  end
                  MODE_CHUNKED: st_next.phase = PH_SIZE;
                  default:      st_next.phase = PH_CLOSE;
                endcase
              end else begin
                l = line_start(st);
                if (st.phase == PH_VALUE) begin
                  if (st.length_name_hit && st.name_position == 5'(NAME_LEN_CHARS)) begin
                    l.body_mode      = MODE_FIXED;
                    l.content_length = st.number_negative ? '0 : st.remaining;
                  end
                  if (st.encoding_name_hit && st.name_position == 5'(NAME_ENC_CHARS) &&
                      st.chunked_value_hit && st.value_position == 4'(VAL_CHK_CHARS))
                    l.body_mode = MODE_CHUNKED;
                end
                l.phase      = PH_NAME;
                l.pending_cr = 1'b0;
                st_next      = l;
              end
            end else begin
              // A held CR not followed by LF is plain text
              if (st.pending_cr) l = text_byte(l, CHAR_CR);
              l.pending_cr = (b == CHAR_CR);
              if (b != CHAR_CR) l = text_byte(l, b);
              st_next = l;
            end
          end
          PH_FIXED: begin
            st_next.remaining = rem_dec;
            if (rem_dec == '0) st_next.phase = PH_DONE;
          end
          PH_SIZE: begin
            if (b == CHAR_LF) begin
              st_next.phase = (st.remaining == '0) ? PH_DONE : PH_DATA;
            end else if (b != CHAR_CR) begin
              if (!hex[4]) st_next.phase = PH_DONE;
              else st_next.remaining = sat_hex(st.remaining, hex[3:0]);
            end
          end
          PH_DATA: begin
            st_next.remaining = rem_dec;
            if (rem_dec == '0) begin
              st_next.phase      = PH_SKIP;
              st_next.skip_count = 2'd2;
            end
          end
          PH_SKIP: begin
            st_next.skip_count = skip_dec;
            if (skip_dec == 2'd0) begin
              st_next.phase     = PH_SIZE;
              st_next.remaining = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result for the request taken this cycle
  always_comb begin
    res_valid = 1'b0;
    res       = '{body_byte: 8'h00, status: STAT_BODY, last: 1'b0};
    if (take) begin
      if (item.action) begin
        if (st.phase != PH_DONE) begin
          res_valid = 1'b1;
          res       = '{body_byte: 8'h00, status: STAT_END, last: 1'b1};
        end
      end else begin
        unique case (st.phase) inside
          PH_STATUS, PH_NAME, PH_VALUE: begin
            if (crlf && st.line_empty && st.body_mode == MODE_FIXED &&
                st.content_length == '0) begin
              res_valid = 1'b1;
              res       = '{body_byte: 8'h00, status: STAT_END, last: 1'b1};
            end
          end
          PH_CLOSE, PH_DATA: begin
            res_valid = 1'b1;
            res       = '{body_byte: b, status: STAT_BODY, last: 1'b0};
          end
          PH_FIXED: begin
            res_valid = 1'b1;
            res       = '{body_byte: b, status: STAT_BODY, last: (rem_dec == '0)};
          end
          PH_SIZE: begin
            if (b == CHAR_LF) begin
              if (st.remaining == '0) begin
                res_valid = 1'b1;
                res       = '{body_byte: 8'h00, status: STAT_END, last: 1'b1};
              end
            end else if (b != CHAR_CR && !hex[4]) begin
              res_valid = 1'b1;
              res       = '{body_byte: 8'h00, status: STAT_BAD_SIZE, last: 1'b1};
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: src/hbd_out_reg.sv
module hbd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  hbd_pkg::result_t res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       body_byte,
  output logic [1:0]       status,
  output logic             last
);
  import hbd_pkg::*;

  result_t data;

  assign free      = !out_valid || out_ready;
  assign body_byte = data.body_byte;
  assign status    = data.status;
  assign last      = data.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

FILE: src/hbd_checker.sv
module hbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       action,
  input logic [7:0] data_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] body_byte,
  input logic [1:0] status,
  input logic       last
);
  import hbd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(body_byte) && $stable(status) &&
                                $stable(last))
    else $error("result changed while stalled");

  // An end or error result carries no byte and closes the response
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_BODY |-> last && body_byte == 8'h00)
    else $error("end or error result without last");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STAT_BODY || status == STAT_END || status == STAT_BAD_SIZE)
    else $error("unknown status code");

  // Nothing follows the last result
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid)
    else $error("result after last");

  // An empty output side never blocks input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind http_response_body_deframer hbd_checker u_hbd_checker (.*);
